@@ rtl/bdar_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdar_pkg
// Shared constants and types for the button debounce / auto-repeat unit.
// ----------------------------------------------------------------------------
package bdar_pkg;

    localparam int NUM_BUTTONS = 3;
    localparam int CNT_W       = 8;
    localparam int TIMER_W     = 8;
    localparam int CFG_DATA_W  = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int NUM_CHECKS  = 3;
    localparam int CHK_IDX_W   = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CONF_TH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BURST_TH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BURST_EN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CP_FIRST = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CP_SECND = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CP_THIRD = 3'd5;

    // reset values of the configuration registers
    localparam logic [CNT_W-1:0]       RST_CONF_TH  = 8'd3;
    localparam logic [CNT_W-1:0]       RST_BURST_TH = 8'd20;
    localparam logic [NUM_BUTTONS-1:0] RST_BURST_EN = 3'b011;
    localparam logic [TIMER_W-1:0]     RST_CP_FIRST = 8'h40;
    localparam logic [TIMER_W-1:0]     RST_CP_SECND = 8'h80;
    localparam logic [TIMER_W-1:0]     RST_CP_THIRD = 8'hC0;

    // checkpoint index value meaning "all checkpoints passed"
    localparam logic [CHK_IDX_W-1:0] CHK_DONE = 2'd3;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef logic [TIMER_W-1:0] t_check_points [NUM_CHECKS];

    typedef struct packed {
        logic [CNT_W-1:0] conf_th;
        logic [CNT_W-1:0] burst_th;
    } t_lane_cfg;

    typedef struct packed {
        logic step;   // sample taken on an accepted poll, button enabled
        logic low;    // pin reads pressed
        logic burst;  // auto-repeat enabled for this button
    } t_lane_ctl;

    typedef struct packed {
        logic fire;
        logic pressed;
    } t_lane_res;

endpackage

@@ rtl/button_debounce_auto_repeat_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_auto_repeat_unit
// An input transfer's result loads into the output register in the next cycle.
// Throughput: one poll per cycle; a held result stalls polls until it moves.
// Reset (i_rst_n low, synchronous): counters, pressed flags, checkpoint index and
// output valid clear; configuration returns to its default values.
// ----------------------------------------------------------------------------
// Three button lanes run side by side on every poll. The scheduler decides
// whether the poll is a sample point; each lane updates its own counters,
// and the merge stage packs fire and pressed bits into the result register.
// ----------------------------------------------------------------------------
module button_debounce_auto_repeat_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [bdar_pkg::CFG_IDX_W-1:0]      i_cfg_addr,
    input  logic [bdar_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    // poll input channel
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_timer_overflow,
    input  logic [bdar_pkg::TIMER_W-1:0]        i_timer_value,
    input  logic [bdar_pkg::NUM_BUTTONS-1:0]    i_pin_levels,
    input  logic                                i_updown_enabled,
    // result channel
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_sample_taken,
    output logic [bdar_pkg::NUM_BUTTONS-1:0]    o_event_fire,
    output logic [bdar_pkg::NUM_BUTTONS-1:0]    o_pressed_flags
);

    // ---------------- configuration registers ----------------
    logic [bdar_pkg::CNT_W-1:0]       r_conf_th;
    logic [bdar_pkg::CNT_W-1:0]       r_burst_th;
    logic [bdar_pkg::NUM_BUTTONS-1:0] r_burst_en;
    bdar_pkg::t_check_points          r_check_points;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conf_th         <= bdar_pkg::RST_CONF_TH;
            r_burst_th        <= bdar_pkg::RST_BURST_TH;
            r_burst_en        <= bdar_pkg::RST_BURST_EN;
            r_check_points[0] <= bdar_pkg::RST_CP_FIRST;
            r_check_points[1] <= bdar_pkg::RST_CP_SECND;
            r_check_points[2] <= bdar_pkg::RST_CP_THIRD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                bdar_pkg::CFG_CONF_TH:  r_conf_th         <= i_cfg_wdata;
                bdar_pkg::CFG_BURST_TH: r_burst_th        <= i_cfg_wdata;
                bdar_pkg::CFG_BURST_EN:
                    r_burst_en <= i_cfg_wdata[bdar_pkg::NUM_BUTTONS-1:0];
                bdar_pkg::CFG_CP_FIRST: r_check_points[0] <= i_cfg_wdata;
                bdar_pkg::CFG_CP_SECND: r_check_points[1] <= i_cfg_wdata;
                bdar_pkg::CFG_CP_THIRD: r_check_points[2] <= i_cfg_wdata;
                default: ;  // unmapped index: write is dropped
            endcase
        end
    end

    // ---------------- handshake ----------------
    // A new poll moves in whenever the result register is empty or its
    // content is taken in the same cycle.
    logic in_xfer;
    assign o_ready = !o_valid || i_ready;
    assign in_xfer = i_valid && o_ready;

    // ---------------- sample scheduler ----------------
    logic sample;

    bdar_sched u_sched (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (in_xfer),
        .i_timer_overflow (i_timer_overflow),
        .i_timer_value    (i_timer_value),
        .i_check_points   (r_check_points),
        .o_sample         (sample)
    );

    // ---------------- button lanes ----------------
    bdar_pkg::t_lane_cfg lane_cfg;
    bdar_pkg::t_lane_ctl lane_ctl [bdar_pkg::NUM_BUTTONS];
    bdar_pkg::t_lane_res lane_res [bdar_pkg::NUM_BUTTONS];

    assign lane_cfg.conf_th  = r_conf_th;
    assign lane_cfg.burst_th = r_burst_th;

    for (genvar g = 0; g < bdar_pkg::NUM_BUTTONS; g++) begin : g_lane
        // buttons 0 and 1 follow the up/down enable, the rest are always on
        logic enabled;
        assign enabled = (g >= 2) || i_updown_enabled;

        assign lane_ctl[g].step  = in_xfer && sample && enabled;
        assign lane_ctl[g].low   = !i_pin_levels[g];
        assign lane_ctl[g].burst = r_burst_en[g];

        bdar_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cfg   (lane_cfg),
            .i_ctl   (lane_ctl[g]),
            .o_res   (lane_res[g])
        );
    end

    // ---------------- merge stage / result register ----------------
    logic [bdar_pkg::NUM_BUTTONS-1:0] fire_vec;
    logic [bdar_pkg::NUM_BUTTONS-1:0] pressed_vec;

    always_comb begin
        for (int b = 0; b < bdar_pkg::NUM_BUTTONS; b++) begin
            fire_vec[b]    = lane_res[b].fire;
            pressed_vec[b] = lane_res[b].pressed;
        end
    end

    logic                             r_out_valid;
    logic                             r_sample_taken;
    logic [bdar_pkg::NUM_BUTTONS-1:0] r_event_fire;
    logic [bdar_pkg::NUM_BUTTONS-1:0] r_pressed_flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_ready) begin
            r_out_valid <= i_valid;
        end
    end

    // payload only loads on an input transfer, so a stalled result holds
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_sample_taken  <= sample;
            r_event_fire    <= fire_vec;
            r_pressed_flags <= pressed_vec;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_sample_taken  = r_sample_taken;
    assign o_event_fire    = r_event_fire;
    assign o_pressed_flags = r_pressed_flags;

endmodule

@@ rtl/bdar_sched.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdar_sched
// Sample scheduler: decides whether a poll is a debounce sample point.
// ----------------------------------------------------------------------------
module bdar_sched (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_accept,
    input  logic                             i_timer_overflow,
    input  logic [bdar_pkg::TIMER_W-1:0]     i_timer_value,
    input  bdar_pkg::t_check_points          i_check_points,
    output logic                             o_sample
);

    logic [bdar_pkg::CHK_IDX_W-1:0] r_check_index;
    logic [bdar_pkg::CHK_IDX_W-1:0] n_check_index;
    logic [bdar_pkg::TIMER_W-1:0]   cur_point;
    logic                           point_hit;

    always_comb begin
        unique case (r_check_index)
            2'd0:    cur_point = i_check_points[0];
            2'd1:    cur_point = i_check_points[1];
            2'd2:    cur_point = i_check_points[2];
            default: cur_point = '0;
        endcase
    end

    assign point_hit = (r_check_index != bdar_pkg::CHK_DONE) &&
                       (i_timer_value >= cur_point);

    always_comb begin
        o_sample      = 1'b0;
        n_check_index = r_check_index;
        priority if (i_timer_overflow) begin
            o_sample      = 1'b1;
            n_check_index = '0;
        end else if (point_hit) begin
            o_sample      = 1'b1;
            n_check_index = r_check_index + 2'd1;
        end else begin
            o_sample      = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_index <= '0;
        end else if (i_accept) begin
            r_check_index <= n_check_index;
        end
    end

endmodule

@@ rtl/bdar_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdar_lane
// Per-button debounce counter, pressed flag and auto-repeat counter.
// ----------------------------------------------------------------------------
module bdar_lane (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bdar_pkg::t_lane_cfg i_cfg,
    input  bdar_pkg::t_lane_ctl i_ctl,
    output bdar_pkg::t_lane_res o_res
);

    logic [bdar_pkg::CNT_W-1:0] r_conf;
    logic [bdar_pkg::CNT_W-1:0] n_conf;
    logic [bdar_pkg::CNT_W-1:0] r_rep;
    logic [bdar_pkg::CNT_W-1:0] n_rep;
    logic                       r_pressed;
    logic                       n_pressed;
    logic [bdar_pkg::CNT_W-1:0] conf_inc;
    logic                       fire;

    assign conf_inc = (r_conf != bdar_pkg::CNT_MAX) ? r_conf + 8'd1 : r_conf;

    always_comb begin
        n_conf    = r_conf;
        n_rep     = r_rep;
        n_pressed = r_pressed;
        fire      = 1'b0;
        if (i_ctl.step) begin
            if (!i_ctl.low) begin
                // released: drop everything
                n_conf    = '0;
                n_rep     = '0;
                n_pressed = 1'b0;
            end else if (!r_pressed) begin
                n_conf = conf_inc;
                if (conf_inc >= i_cfg.conf_th) begin
                    n_pressed = 1'b1;
                    fire      = 1'b1;
                end
            end else if (i_ctl.burst) begin
                if (r_rep < i_cfg.burst_th) begin
                    n_rep = r_rep + 8'd1;
                end else begin
                    fire = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conf    <= '0;
            r_rep     <= '0;
            r_pressed <= 1'b0;
        end else begin
            r_conf    <= n_conf;
            r_rep     <= n_rep;
            r_pressed <= n_pressed;
        end
    end

    assign o_res.fire    = fire;
    assign o_res.pressed = n_pressed;

endmodule

@@ rtl/bdar_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdar_checker
// Port-level checks for the button debounce / auto-repeat unit.
// ----------------------------------------------------------------------------
module bdar_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic                                o_ready,
    input  logic                                i_timer_overflow,
    input  logic [bdar_pkg::NUM_BUTTONS-1:0]    i_pin_levels,
    input  logic                                i_updown_enabled,
    input  logic                                o_valid,
    input  logic                                i_ready,
    input  logic                                o_sample_taken,
    input  logic [bdar_pkg::NUM_BUTTONS-1:0]    o_event_fire,
    input  logic [bdar_pkg::NUM_BUTTONS-1:0]    o_pressed_flags
);

    // a stalled result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_sample_taken) &&
        $stable(o_event_fire) && $stable(o_pressed_flags))
        else $error("result changed while stalled");

    // no fire without a sample point
    a_fire_needs_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_sample_taken |-> o_event_fire == '0)
        else $error("fire on a poll that was not a sample");

    // a firing button is a pressed button
    a_fire_pressed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_event_fire & ~o_pressed_flags) == '0)
        else $error("fire on a button that is not pressed");

    // an overflow poll always reports a sample in the next result
    a_overflow_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_timer_overflow |=> o_valid && o_sample_taken)
        else $error("overflow poll did not sample");

    // an overflow sample with a high pin clears that button (all buttons enabled)
    a_release_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_timer_overflow && i_updown_enabled |=>
        (o_pressed_flags & $past(i_pin_levels)) == '0)
        else $error("released button still reported pressed");

endmodule

bind button_debounce_auto_repeat_unit bdar_checker u_bdar_checker (.*);

@@ verif/tb_button_debounce_auto_repeat_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_debounce_auto_repeat_unit
// Self-checking bench for the debounce / auto-repeat unit. A debounce tracker
// class keeps its own copy of the checkpoint index, per-button counters and
// pressed flags, predicts one result per accepted poll and compares every
// result transfer field by field. Stimulus: a short directed run over sample
// scheduling, presses, releases, disabled buttons and threshold corner cases,
// then random timer ramps with held/bouncing pins under several register
// settings and changing idle patterns on both channels.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic                             sample;
    logic [bdar_pkg::NUM_BUTTONS-1:0] fire;
    logic [bdar_pkg::NUM_BUTTONS-1:0] pressed;
} t_poll_result;

// Tracks debounce state from accepted polls and checks the result stream.
class debounce_tracker;
    logic [bdar_pkg::CNT_W-1:0]       conf_th;
    logic [bdar_pkg::CNT_W-1:0]       burst_th;
    logic [bdar_pkg::NUM_BUTTONS-1:0] burst_en;
    logic [bdar_pkg::TIMER_W-1:0]     check_pt [bdar_pkg::NUM_CHECKS];

    logic [bdar_pkg::CHK_IDX_W-1:0]   chk_idx;
    logic [bdar_pkg::CNT_W-1:0]       low_cnt  [bdar_pkg::NUM_BUTTONS];
    logic [bdar_pkg::CNT_W-1:0]       held_cnt [bdar_pkg::NUM_BUTTONS];
    logic [bdar_pkg::NUM_BUTTONS-1:0] key_down;

    t_poll_result expected_polls[$];
    int           mismatches;

    function new();
        conf_th     = bdar_pkg::RST_CONF_TH;
        burst_th    = bdar_pkg::RST_BURST_TH;
        burst_en    = bdar_pkg::RST_BURST_EN;
        check_pt[0] = bdar_pkg::RST_CP_FIRST;
        check_pt[1] = bdar_pkg::RST_CP_SECND;
        check_pt[2] = bdar_pkg::RST_CP_THIRD;
        chk_idx     = '0;
        key_down    = '0;
        mismatches  = 0;
        for (int b = 0; b < bdar_pkg::NUM_BUTTONS; b++) begin
            low_cnt[b]  = '0;
            held_cnt[b] = '0;
        end
    endfunction

    function void write_reg(logic [bdar_pkg::CFG_IDX_W-1:0] idx,
                            logic [bdar_pkg::CFG_DATA_W-1:0] val);
        case (idx)
            bdar_pkg::CFG_CONF_TH:  conf_th     = val;
            bdar_pkg::CFG_BURST_TH: burst_th    = val;
            bdar_pkg::CFG_BURST_EN: burst_en    = val[bdar_pkg::NUM_BUTTONS-1:0];
            bdar_pkg::CFG_CP_FIRST: check_pt[0] = val;
            bdar_pkg::CFG_CP_SECND: check_pt[1] = val;
            bdar_pkg::CFG_CP_THIRD: check_pt[2] = val;
            default: ;
        endcase
    endfunction

    // accepted poll: advance state, queue the result it must produce
    function void note_poll(logic ovf, logic [bdar_pkg::TIMER_W-1:0] tv,
                            logic [bdar_pkg::NUM_BUTTONS-1:0] pins, logic updown);
        t_poll_result r;
        int           b;
        r = '0;
        if (ovf) begin
            r.sample = 1'b1;
            chk_idx  = '0;
        end else if (chk_idx != bdar_pkg::CHK_DONE && tv >= check_pt[chk_idx]) begin
            r.sample = 1'b1;
            chk_idx  = chk_idx + 1'b1;
        end
        for (b = 0; b < bdar_pkg::NUM_BUTTONS; b++) begin
            if (r.sample && (b >= 2 || updown)) begin
                if (!pins[b]) begin
                    if (!key_down[b]) begin
                        if (low_cnt[b] != bdar_pkg::CNT_MAX)
                            low_cnt[b] = low_cnt[b] + 1'b1;
                        if (low_cnt[b] >= conf_th) begin
                            key_down[b] = 1'b1;
                            r.fire[b]   = 1'b1;
                        end
                    end else if (burst_en[b]) begin
                        if (held_cnt[b] < burst_th)
                            held_cnt[b] = held_cnt[b] + 1'b1;
                        else
                            r.fire[b] = 1'b1;
                    end
                end else begin
                    low_cnt[b]  = '0;
                    held_cnt[b] = '0;
                    key_down[b] = 1'b0;
                end
            end
        end
        r.pressed = key_down;
        expected_polls.push_back(r);
    endfunction

    function void check_result(logic sample, logic [bdar_pkg::NUM_BUTTONS-1:0] fire,
                               logic [bdar_pkg::NUM_BUTTONS-1:0] pressed);
        t_poll_result e;
        if (expected_polls.size() == 0) begin
            $error("result transfer with no poll outstanding");
            mismatches++;
            return;
        end
        e = expected_polls.pop_front();
        if (sample !== e.sample) begin
            $error("sample_taken expected %0h actual %0h", e.sample, sample);
            mismatches++;
        end
        if (fire !== e.fire) begin
            $error("event_fire expected %0h actual %0h", e.fire, fire);
            mismatches++;
        end
        if (pressed !== e.pressed) begin
            $error("pressed_flags expected %0h actual %0h", e.pressed, pressed);
            mismatches++;
        end
    endfunction

    function int pending();
        return expected_polls.size();
    endfunction
endclass

module tb_button_debounce_auto_repeat_unit;

    localparam int CLK_HALF    = 6;
    localparam int LAT_SLACK   = 4;       // extra wait at the end of a drain
    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASE_POLLS = 330;
    // decodes to no register
    localparam logic [bdar_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_cfg_we;
    logic [bdar_pkg::CFG_IDX_W-1:0]   i_cfg_addr;
    logic [bdar_pkg::CFG_DATA_W-1:0]  i_cfg_wdata;
    logic                             i_valid;
    logic                             o_ready;
    logic                             i_timer_overflow;
    logic [bdar_pkg::TIMER_W-1:0]     i_timer_value;
    logic [bdar_pkg::NUM_BUTTONS-1:0] i_pin_levels;
    logic                             i_updown_enabled;
    logic                             o_valid;
    logic                             i_ready;
    logic                             o_sample_taken;
    logic [bdar_pkg::NUM_BUTTONS-1:0] o_event_fire;
    logic [bdar_pkg::NUM_BUTTONS-1:0] o_pressed_flags;

    debounce_tracker tracker;

    // idle percentages for the two channels, changed per phase
    int tx_idle_pct;
    int rx_idle_pct;
    int cycle_cnt;

    // random stimulus state carried across phases
    int                               timer_acc;
    logic [bdar_pkg::NUM_BUTTONS-1:0] held_pins;

    button_debounce_auto_repeat_unit uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_timer_overflow (i_timer_overflow),
        .i_timer_value    (i_timer_value),
        .i_pin_levels     (i_pin_levels),
        .i_updown_enabled (i_updown_enabled),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_sample_taken   (o_sample_taken),
        .o_event_fire     (o_event_fire),
        .o_pressed_flags  (o_pressed_flags)
    );

    always begin
        i_clk = 1'b1;
        #CLK_HALF;
        i_clk = 1'b0;
        #CLK_HALF;
    end

    // hang guard
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb_button_debounce_auto_repeat_unit: errors");
            $finish;
        end
    end

    // result side back-pressure
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Transfer monitor. Everything here reads pre-edge values, as all bench
    // drives are nonblocking. The result leaving at this edge always belongs
    // to an older poll, so it is checked before the new poll is predicted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid === 1'b1 && i_ready)
                tracker.check_result(o_sample_taken, o_event_fire, o_pressed_flags);
            if (i_valid && o_ready === 1'b1)
                tracker.note_poll(i_timer_overflow, i_timer_value, i_pin_levels,
                                  i_updown_enabled);
        end
    end

    // One poll transfer. Sender idle cycles come first, each drawn on its own;
    // valid is only ever raised here and only lowered in the gap or when draining.
    task automatic send_poll(logic ovf, logic [bdar_pkg::TIMER_W-1:0] tv,
                             logic [bdar_pkg::NUM_BUTTONS-1:0] pins, logic updown);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_timer_overflow <= ovf;
        i_timer_value    <= tv;
        i_pin_levels     <= pins;
        i_updown_enabled <= updown;
        @(posedge i_clk);
        while (o_ready !== 1'b1) @(posedge i_clk);
    endtask

    // Stop sending and wait until every predicted result has moved out.
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (LAT_SLACK) @(posedge i_clk);
    endtask

    // Full register load, plus a write to an unmapped index that must be
    // ignored. Only called with the unit drained.
    task automatic program_regs(logic [bdar_pkg::CFG_DATA_W-1:0] conf,
                                logic [bdar_pkg::CFG_DATA_W-1:0] burst,
                                logic [bdar_pkg::CFG_DATA_W-1:0] mask,
                                logic [bdar_pkg::CFG_DATA_W-1:0] cp0,
                                logic [bdar_pkg::CFG_DATA_W-1:0] cp1,
                                logic [bdar_pkg::CFG_DATA_W-1:0] cp2);
        logic [bdar_pkg::CFG_IDX_W-1:0]  idx  [7];
        logic [bdar_pkg::CFG_DATA_W-1:0] vals [7];
        int                              k;
        idx  = '{bdar_pkg::CFG_CONF_TH, bdar_pkg::CFG_BURST_TH, bdar_pkg::CFG_BURST_EN,
                 bdar_pkg::CFG_CP_FIRST, bdar_pkg::CFG_CP_SECND, bdar_pkg::CFG_CP_THIRD,
                 CFG_SPARE};
        vals = '{conf, burst, mask, cp0, cp1, cp2,
                 bdar_pkg::CFG_DATA_W'($urandom_range(0, 255))};
        for (k = 0; k < 7; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_addr  <= idx[k];
            i_cfg_wdata <= vals[k];
            @(posedge i_clk);
            tracker.write_reg(idx[k], vals[k]);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random register setting; checkpoints sorted unless out_of_order.
    task automatic program_random(int conf_hi, int burst_hi, bit out_of_order);
        logic [bdar_pkg::TIMER_W-1:0] cp [3];
        logic [bdar_pkg::TIMER_W-1:0] tmp;
        int                           a;
        int                           b;
        for (a = 0; a < 3; a++) cp[a] = bdar_pkg::TIMER_W'($urandom_range(0, 255));
        if (!out_of_order) begin
            for (a = 0; a < 2; a++)
                for (b = 0; b < 2 - a; b++)
                    if (cp[b] > cp[b+1]) begin
                        tmp     = cp[b];
                        cp[b]   = cp[b+1];
                        cp[b+1] = tmp;
                    end
        end
        program_regs(bdar_pkg::CFG_DATA_W'($urandom_range(1, conf_hi)),
                     bdar_pkg::CFG_DATA_W'($urandom_range(0, burst_hi)),
                     bdar_pkg::CFG_DATA_W'($urandom_range(0, 255)), cp[0], cp[1], cp[2]);
    endtask

    // Random polls: a ramping timer whose wrap, or a random draw, is the overflow,
    // buttons held for stretches, plus timer jumps and one-poll pin bounces.
    task automatic run_polls(int count, int ovf_pct, int flip_pm, int noise_pct);
        logic                             ovf;
        logic [bdar_pkg::TIMER_W-1:0]     tv;
        logic [bdar_pkg::NUM_BUTTONS-1:0] pins;
        int                               k;
        int                               b;
        for (k = 0; k < count; k++) begin
            timer_acc = timer_acc + $urandom_range(0, 40);
            ovf = (timer_acc > 255) || ($urandom_range(0, 99) < ovf_pct);
            if (ovf)
                timer_acc = $urandom_range(0, 31);
            tv = timer_acc[bdar_pkg::TIMER_W-1:0];
            if ($urandom_range(0, 99) < noise_pct)
                tv = bdar_pkg::TIMER_W'($urandom_range(0, 255));
            for (b = 0; b < bdar_pkg::NUM_BUTTONS; b++)
                if ($urandom_range(0, 999) < flip_pm)
                    held_pins[b] = ~held_pins[b];
            pins = held_pins;
            if ($urandom_range(0, 99) < noise_pct)
                pins = pins ^ bdar_pkg::NUM_BUTTONS'($urandom_range(1, 7));
            send_poll(ovf, tv, pins, $urandom_range(0, 19) != 0);
        end
    endtask

    initial begin
        int ph;
        tracker          = new();
        cycle_cnt        = 0;
        timer_acc        = 0;
        held_pins        = '1;
        tx_idle_pct      = 12;
        rx_idle_pct      = 61;
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_addr       <= '0;
        i_cfg_wdata      <= '0;
        i_valid          <= 1'b0;
        i_ready          <= 1'b0;
        i_timer_overflow <= 1'b0;
        i_timer_value    <= '0;
        i_pin_levels     <= '1;
        i_updown_enabled <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed, reset defaults: thresholds 3/20, repeat on buttons 0,1
        send_poll(1'b0, 8'h00, 3'b111, 1'b1);   // below first checkpoint: no sample
        send_poll(1'b0, 8'hFF, 3'b000, 1'b1);   // first checkpoint, one low sample
        send_poll(1'b0, 8'h80, 3'b000, 1'b1);   // second checkpoint exactly
        send_poll(1'b0, 8'h7F, 3'b000, 1'b1);   // third checkpoint not reached
        send_poll(1'b0, 8'hC0, 3'b000, 1'b1);   // third sample: all three press
        send_poll(1'b0, 8'hFF, 3'b000, 1'b1);   // all checkpoints passed
        send_poll(1'b1, 8'h00, 3'b000, 1'b0);   // overflow, buttons 0/1 disabled
        send_poll(1'b1, 8'h00, 3'b001, 1'b1);   // button 0 released, 1 counts held
        send_poll(1'b1, 8'hFF, 3'b111, 1'b0);   // only button 2 sees the release
        send_poll(1'b1, 8'hAA, 3'b101, 1'b1);   // button 1 still held

        // --- lowered burst threshold with a held key, checkpoints out of order
        drain_results();
        program_regs(8'd1, 8'd0, 8'hFF, 8'hFF, 8'h00, 8'h10);
        send_poll(1'b1, 8'h00, 3'b000, 1'b1);   // held count above new threshold
        send_poll(1'b0, 8'hFE, 3'b000, 1'b1);
        send_poll(1'b0, 8'hFF, 3'b000, 1'b1);
        send_poll(1'b0, 8'h00, 3'b000, 1'b1);
        send_poll(1'b0, 8'h0F, 3'b000, 1'b1);
        send_poll(1'b0, 8'h10, 3'b000, 1'b1);
        send_poll(1'b0, 8'hFF, 3'b010, 1'b1);

        // --- zero confidence threshold, widest burst threshold, no repeat
        drain_results();
        program_regs(8'd0, 8'd255, 8'h00, 8'h00, 8'h00, 8'h00);
        send_poll(1'b1, 8'h00, 3'b111, 1'b1);
        send_poll(1'b0, 8'h00, 3'b000, 1'b1);   // presses on first low sample
        send_poll(1'b0, 8'h00, 3'b000, 1'b1);
        send_poll(1'b0, 8'h00, 3'b110, 1'b0);
        send_poll(1'b0, 8'h00, 3'b011, 1'b1);   // index done: no sample

        // --- random phases; idle mix changes every two phases
        for (ph = 0; ph < 6; ph++) begin
            drain_results();
            if (ph < 2) begin
                tx_idle_pct = 12;
                rx_idle_pct = 61;
            end else if (ph < 4) begin
                tx_idle_pct = 61;
                rx_idle_pct = 12;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            case (ph)
                0: begin
                    program_random(6, 8, 1'b0);
                    run_polls(PHASE_POLLS, 3, 30, 8);
                end
                1: begin
                    // widest thresholds: dense sampling and long holds so the
                    // confidence count can climb all the way
                    program_regs(8'd255, 8'd255, 8'h07, 8'h00, 8'h00, 8'h00);
                    held_pins = '0;
                    run_polls(PHASE_POLLS, 50, 1, 0);
                end
                2: begin
                    program_regs(8'd1, 8'd0, 8'h07, 8'h20, 8'h90, 8'hF0);
                    run_polls(PHASE_POLLS, 3, 30, 8);
                end
                3: begin
                    program_random(4, 3, 1'b0);
                    run_polls(PHASE_POLLS, 5, 20, 10);
                end
                4: begin
                    program_regs(bdar_pkg::RST_CONF_TH, bdar_pkg::RST_BURST_TH,
                                 8'(bdar_pkg::RST_BURST_EN), bdar_pkg::RST_CP_FIRST,
                                 bdar_pkg::RST_CP_SECND, bdar_pkg::RST_CP_THIRD);
                    run_polls(PHASE_POLLS / 2, 3, 30, 8);
                    drain_results();      // sender holds off until all results moved
                    run_polls(PHASE_POLLS / 2, 3, 30, 8);
                end
                default: begin
                    program_random(8, 12, 1'b1);
                    run_polls(PHASE_POLLS, 4, 25, 8);
                end
            endcase
        end

        drain_results();
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("tb_button_debounce_auto_repeat_unit: clean");
        else
            $display("tb_button_debounce_auto_repeat_unit: errors");
        $finish;
    end

endmodule
